@@ hw/rtl/hwha_pkg.sv @@
// shared types and constants of the header walk heap allocator
// item structs for both channels, command and status codes, field widths
// no dependencies

package hwha_pkg;

  localparam int unsigned REGION_MAX_DEF = 4096;

  localparam int unsigned CMD_W    = 1;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned BYTES_W  = 13;
  localparam int unsigned REG_W    = 13;

  // header entry: used flag on top of the block size
  localparam int unsigned HDR_W     = 9;
  localparam int unsigned AREA_W    = 9;
  localparam int unsigned HDR_BYTES = 2;
  localparam int unsigned AREA_MAX  = 255;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_OK   = 1'b0,
    ST_FAIL = 1'b1
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [SIZE_W-1:0]   payload_size;
    logic [OFFSET_W-1:0] payload_offset;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [OFFSET_W-1:0] granted_offset;
    logic [BYTES_W-1:0]  bytes_left;
  } out_item_t;

endpackage

@@ hw/rtl/header_walk_heap_allocator.sv @@
// header walk heap allocator: first fit on exact block size, no coalescing
// uses hwha_pkg for item types and codes, hwha_ram for the header store
//
//   channel   | direction | handshake               | payload
//   ----------+-----------+-------------------------+---------------------------
//   in        | in        | in_valid_i / in_ready_o | hwha_pkg::in_item_t
//   out       | out       | out_valid_o/out_ready_i | hwha_pkg::out_item_t
//   apb       | in        | psel/penable/pready     | region_bytes at address 0
//
// an allocate reads and checks the headers in turn from the start; it appends
//   or runs out of room past the last one, or stops on a header (reuse or zero
//   size); a fully fragmented region has at most REGION_MAX/3 headers
// a free is a read, modify, write of one header; a refused item only responds
// in_ready_o is high only while the sequencer is idle; one finished result
//   waits in the output register while the next item is taken
// after reset the store needs no clearing pass: a walk only reads headers that
//   an append wrote since the last restart

module header_walk_heap_allocator #(
  parameter int unsigned REGION_MAX = hwha_pkg::REGION_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  hwha_pkg::in_item_t                  in_data_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output hwha_pkg::out_item_t                 out_data_o,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hwha_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [hwha_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [hwha_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned CW    = $clog2(REGION_MAX + 1);
  localparam int unsigned PW    = $clog2(REGION_MAX);
  localparam int unsigned WalkW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam int unsigned AW    = hwha_pkg::AREA_W;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_WALK    = 6'b000010,
    S_CHECK   = 6'b000100,
    S_FREE_RD = 6'b001000,
    S_FREE_WR = 6'b010000,
    S_RESP    = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [WalkW-1:0]              pos_q, pos_d;
  logic [PW-1:0]                 faddr_q, faddr_d;
  logic [AW-1:0]                 area_q, area_d;
  logic [CW-1:0]                 region_q, region_d;
  logic [CW-1:0]                 unres_q, unres_d;
  logic [PW-1:0]                 end_q, end_d;
  logic                          endv_q, endv_d;
  hwha_pkg::status_e             res_st_q, res_st_d;
  logic [hwha_pkg::OFFSET_W-1:0] res_off_q, res_off_d;
  hwha_pkg::out_item_t           out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  logic                          cfg_we;
  logic [CW-1:0]                 cfg_region;
  logic [CW-1:0]                 resvd;
  logic [WalkW-1:0]              resvd_w;
  logic [AW-1:0]                 req_area;
  logic [WalkW-1:0]              free_hdr;
  logic [CW-1:0]                 unres_after;

  logic                          ram_we;
  logic [PW-1:0]                 ram_waddr;
  logic [hwha_pkg::HDR_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [PW-1:0]                 ram_raddr;
  logic [hwha_pkg::HDR_W-1:0]    ram_rdata;
  logic [hwha_pkg::SIZE_W-1:0]   blk_size;
  logic                          blk_used;

  hwha_ram #(
    .WIDTH (hwha_pkg::HDR_W),
    .DEPTH (REGION_MAX)
  ) u_hdr_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // apb side
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[hwha_pkg::APB_ADDR_W-1] == 1'b0);
  assign cfg_region = ({19'd0, pwdata[hwha_pkg::REG_W-1:0]} > 32'(REGION_MAX))
                    ? CW'(REGION_MAX) : CW'(pwdata[hwha_pkg::REG_W-1:0]);
  assign prdata = (paddr[hwha_pkg::APB_ADDR_W-1] == 1'b0)
                ? hwha_pkg::APB_DATA_W'(region_q) : '0;

  assign resvd       = region_q - unres_q;
  assign resvd_w     = WalkW'(resvd);
  assign req_area    = AW'(in_data_i.payload_size) + AW'(hwha_pkg::HDR_BYTES);
  assign free_hdr    = WalkW'(in_data_i.payload_offset) - WalkW'(hwha_pkg::HDR_BYTES);
  assign unres_after = unres_q - CW'(area_q);
  assign blk_size    = ram_rdata[hwha_pkg::SIZE_W-1:0];
  assign blk_used    = ram_rdata[hwha_pkg::HDR_W-1];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    faddr_d     = faddr_q;
    area_d      = area_q;
    region_d    = region_q;
    unres_d     = unres_q;
    end_d       = end_q;
    endv_d      = endv_q;
    res_st_d    = res_st_q;
    res_off_d   = res_off_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = end_q;
    ram_wdata   = {1'b1, area_q[hwha_pkg::SIZE_W-1:0]};
    ram_re      = 1'b0;
    ram_raddr   = PW'(pos_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_st_d  = hwha_pkg::ST_OK;
          res_off_d = '0;
          if (in_data_i.cmd == hwha_pkg::CMD_FREE) begin
            if (in_data_i.payload_offset >= hwha_pkg::OFFSET_W'(hwha_pkg::HDR_BYTES)
                && free_hdr < resvd_w) begin
              faddr_d = PW'(free_hdr);
              state_d = S_FREE_RD;
            end else begin
              state_d = S_RESP;
            end
          end else if (in_data_i.payload_size == '0
                       || req_area > AW'(hwha_pkg::AREA_MAX)) begin
            res_st_d = hwha_pkg::ST_FAIL;
            state_d  = S_RESP;
          end else begin
            area_d  = req_area;
            pos_d   = '0;
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (pos_q < resvd_w) begin
          ram_re  = 1'b1;
          state_d = S_CHECK;
        end else if (!endv_q || WalkW'(unres_q) < WalkW'(area_q)) begin
          res_st_d = hwha_pkg::ST_FAIL;
          state_d  = S_RESP;
        end else begin
          // append a new used block at the reserved end
          ram_we    = 1'b1;
          unres_d   = unres_after;
          res_off_d = hwha_pkg::OFFSET_W'(WalkW'(end_q) + WalkW'(hwha_pkg::HDR_BYTES));
          if (WalkW'(unres_after) < WalkW'(hwha_pkg::HDR_BYTES)) begin
            endv_d = 1'b0;
          end else begin
            end_d = PW'(WalkW'(end_q) + WalkW'(area_q));
          end
          state_d = S_RESP;
        end
      end
      S_CHECK: begin
        if (blk_size == '0) begin
          res_st_d = hwha_pkg::ST_FAIL;
          state_d  = S_RESP;
        end else if (!blk_used && blk_size == area_q[hwha_pkg::SIZE_W-1:0]) begin
          ram_we    = 1'b1;
          ram_waddr = PW'(pos_q);
          ram_wdata = {1'b1, blk_size};
          res_off_d = hwha_pkg::OFFSET_W'(pos_q + WalkW'(hwha_pkg::HDR_BYTES));
          state_d   = S_RESP;
        end else begin
          pos_d   = pos_q + WalkW'(blk_size);
          state_d = S_WALK;
        end
      end
      S_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = faddr_q;
        state_d   = S_FREE_WR;
      end
      S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = faddr_q;
        ram_wdata = {1'b0, blk_size};
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status         = res_st_q;
          out_d.granted_offset = res_off_q;
          out_d.bytes_left     = hwha_pkg::BYTES_W'(unres_q);
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a region size write restarts the allocator empty
    if (cfg_we) begin
      region_d = cfg_region;
      unres_d  = cfg_region;
      end_d    = '0;
      endv_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      region_q    <= CW'(REGION_MAX);
      unres_q     <= CW'(REGION_MAX);
      end_q       <= '0;
      endv_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      region_q    <= region_d;
      unres_q     <= unres_d;
      end_q       <= end_d;
      endv_q      <= endv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    faddr_q   <= faddr_d;
    area_q    <= area_d;
    res_st_q  <= res_st_d;
    res_off_q <= res_off_d;
    out_q     <= out_d;
  end

endmodule

@@ hw/rtl/hwha_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// used for the header store; no package dependency

module hwha_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
